// File: src/projection_matrix_builder_top_defines.svh
// Assertion macros for the projection matrix builder checker.
`ifndef PROJECTION_MATRIX_BUILDER_TOP_DEFINES_SVH
`define PROJECTION_MATRIX_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PMB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmb check failed");

// Next-cycle implication, disabled while in reset.
`define PMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmb check failed");

`endif

// File: src/pmb_pkg.sv
// ----------------------------------------------------------------------------
// pmb_pkg
// Shared widths and constants for the projection matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none
package pmb_pkg;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIFF_W  = DATA_W + 1;
  localparam int unsigned NUM_W   = 2 * DATA_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LANES   = 6;
  localparam int unsigned DIV_LAT = DATA_W + 2;
  localparam logic [NUM_W-1:0] TWO_Q32 = NUM_W'(64'h2_0000_0000);
  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic FUNC_FRUSTUM = 1'b0;
  localparam logic FUNC_ORTHO   = 1'b1;
endpackage
`default_nettype wire

// File: src/pmb_divider.sv
// ----------------------------------------------------------------------------
// pmb_divider
// Pipelined restoring divider: 64-bit magnitude over 33-bit magnitude, one
// quotient bit per stage, sign applied and saturated to signed 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module pmb_divider (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [pmb_pkg::NUM_W-1:0]      num_i,
  input  wire logic [pmb_pkg::DIFF_W-1:0]     den_i,
  input  wire logic                           neg_i,
  output logic      [pmb_pkg::DATA_W-1:0]     res_o
);
  import pmb_pkg::*;

  localparam int unsigned QB = DATA_W;

  logic [DIFF_W-1:0] rem_r [0:QB];
  logic [DATA_W-1:0] lo_r  [0:QB];
  logic [DATA_W-1:0] q_r   [0:QB];
  logic [DIFF_W-1:0] den_r [0:QB];
  logic              neg_r [0:QB];
  logic              ovf_r [0:QB];
  logic [DATA_W-1:0] res_r;
  logic [DATA_W-1:0] res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, num_i[NUM_W-1:DATA_W]};
      lo_r[0]  <= num_i[DATA_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den_i;
      neg_r[0] <= neg_i;
      ovf_r[0] <= ({1'b0, num_i[NUM_W-1:DATA_W]} >= den_i);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DIFF_W:0] trial;
    logic            ge;
    assign trial = {rem_r[s], lo_r[s][DATA_W-1]};
    assign ge    = (trial >= {1'b0, den_r[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? DIFF_W'(trial - {1'b0, den_r[s]}) : trial[DIFF_W-1:0];
        lo_r[s+1]  <= {lo_r[s][DATA_W-2:0], 1'b0};
        q_r[s+1]   <= {q_r[s][DATA_W-2:0], ge};
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  always_comb begin
    if (neg_r[QB]) begin
      if (ovf_r[QB] || (q_r[QB] > SAT_NEG)) begin
        res_nxt = SAT_NEG;
      end else begin
        res_nxt = DATA_W'(~q_r[QB] + 1'b1);
      end
    end else begin
      res_nxt = (ovf_r[QB] || q_r[QB][DATA_W-1]) ? SAT_POS : q_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;
endmodule
`default_nettype wire

// File: src/projection_matrix_builder_top.sv
// ----------------------------------------------------------------------------
// projection_matrix_builder_top
// Frustum / ortho projection matrix terms from six Q16.16 clip bounds.
// ----------------------------------------------------------------------------
// Takes one bound set per cycle while the output is not stalled and returns
// the six variable matrix terms through 37 register stages, one result per
// transaction. The depth is set by the six parallel restoring dividers (34
// stages each, one quotient bit per step stage) plus three operand stages.
// The whole pipeline holds while the output is stalled.
`default_nettype none
module projection_matrix_builder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_left_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_right_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_bottom_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_top_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_near_plane,
  input  wire logic [pmb_pkg::DATA_W-1:0]    in_far_plane,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pmb_pkg::DATA_W-1:0]    out_x_scale,
  output logic      [pmb_pkg::DATA_W-1:0]    out_x_offset,
  output logic      [pmb_pkg::DATA_W-1:0]    out_y_scale,
  output logic      [pmb_pkg::DATA_W-1:0]    out_y_offset,
  output logic      [pmb_pkg::DATA_W-1:0]    out_z_scale,
  output logic      [pmb_pkg::DATA_W-1:0]    out_z_offset,
  output logic                               out_degenerate
);
  import pmb_pkg::*;

  localparam int unsigned DEPTH = DIV_LAT + 3;

  logic adv;
  logic [DEPTH-1:0] vld_r;
  // degenerate flag enters at stage B, one stage after valid
  logic [DEPTH-2:0] deg_r;

  // stage A: capture
  logic                     func_a_r;
  logic signed [DATA_W-1:0] l_a_r, r_a_r, b_a_r, t_a_r, n_a_r, f_a_r;

  // stage B: differences, sums, product
  logic                     func_b_r;
  logic signed [DIFF_W-1:0] dx_b_r, dy_b_r, dz_b_r, sx_b_r, sy_b_r, sz_b_r;
  logic signed [DATA_W-1:0] n_b_r;
  logic signed [NUM_W-1:0]  fn_b_r;

  // stage C: magnitudes and signs
  logic [NUM_W-1:0]  num_c_r [0:LANES-1];
  logic [DIFF_W-1:0] den_c_r [0:LANES-1];
  logic              neg_c_r [0:LANES-1];
  logic [DATA_W-1:0] res    [0:LANES-1];

  logic signed [NUM_W:0]    num_s [0:LANES-1];
  logic signed [DIFF_W-1:0] den_s [0:LANES-1];
  logic                     negf  [0:LANES-1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func_a_r <= in_func;
      l_a_r    <= in_left_bound;
      r_a_r    <= in_right_bound;
      b_a_r    <= in_bottom_bound;
      t_a_r    <= in_top_bound;
      n_a_r    <= in_near_plane;
      f_a_r    <= in_far_plane;

      func_b_r <= func_a_r;
      dx_b_r   <= DIFF_W'(r_a_r) - DIFF_W'(l_a_r);
      dy_b_r   <= DIFF_W'(t_a_r) - DIFF_W'(b_a_r);
      dz_b_r   <= DIFF_W'(f_a_r) - DIFF_W'(n_a_r);
      sx_b_r   <= DIFF_W'(r_a_r) + DIFF_W'(l_a_r);
      sy_b_r   <= DIFF_W'(t_a_r) + DIFF_W'(b_a_r);
      sz_b_r   <= DIFF_W'(f_a_r) + DIFF_W'(n_a_r);
      n_b_r    <= n_a_r;
      fn_b_r   <= NUM_W'(f_a_r) * NUM_W'(n_a_r);
      deg_r    <= {deg_r[DEPTH-3:0],
                   (r_a_r == l_a_r) || (t_a_r == b_a_r) || (f_a_r == n_a_r)};
    end
  end

  always_comb begin
    den_s[0] = dx_b_r; den_s[1] = dx_b_r;
    den_s[2] = dy_b_r; den_s[3] = dy_b_r;
    den_s[4] = dz_b_r; den_s[5] = dz_b_r;
    if (func_b_r == FUNC_ORTHO) begin
      num_s[0] = (NUM_W+1)'(signed'({1'b0, TWO_Q32}));
      num_s[1] = (NUM_W+1)'(sx_b_r) <<< FRAC_W;
      num_s[2] = (NUM_W+1)'(signed'({1'b0, TWO_Q32}));
      num_s[3] = (NUM_W+1)'(sy_b_r) <<< FRAC_W;
      num_s[4] = (NUM_W+1)'(signed'({1'b0, TWO_Q32}));
      num_s[5] = (NUM_W+1)'(sz_b_r) <<< FRAC_W;
      negf[0] = 1'b0; negf[1] = 1'b1; negf[2] = 1'b0;
      negf[3] = 1'b1; negf[4] = 1'b1; negf[5] = 1'b1;
    end else begin
      num_s[0] = (NUM_W+1)'(n_b_r) <<< (FRAC_W + 1);
      num_s[1] = (NUM_W+1)'(sx_b_r) <<< FRAC_W;
      num_s[2] = (NUM_W+1)'(n_b_r) <<< (FRAC_W + 1);
      num_s[3] = (NUM_W+1)'(sy_b_r) <<< FRAC_W;
      num_s[4] = (NUM_W+1)'(sz_b_r) <<< FRAC_W;
      num_s[5] = (NUM_W+1)'(fn_b_r) <<< 1;
      negf[0] = 1'b0; negf[1] = 1'b0; negf[2] = 1'b0;
      negf[3] = 1'b0; negf[4] = 1'b1; negf[5] = 1'b1;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        num_c_r[k] <= num_s[k][NUM_W] ? NUM_W'(-num_s[k]) : num_s[k][NUM_W-1:0];
        den_c_r[k] <= den_s[k][DIFF_W-1] ? DIFF_W'(-den_s[k]) : DIFF_W'(den_s[k]);
        neg_c_r[k] <= num_s[k][NUM_W] ^ den_s[k][DIFF_W-1] ^ negf[k];
      end
    end

    pmb_divider u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num_c_r[k]),
      .den_i (den_c_r[k]),
      .neg_i (neg_c_r[k]),
      .res_o (res[k])
    );
  end

  assign out_valid      = vld_r[DEPTH-1];
  assign out_degenerate = deg_r[DEPTH-2];
  assign out_x_scale    = out_degenerate ? '0 : res[0];
  assign out_x_offset   = out_degenerate ? '0 : res[1];
  assign out_y_scale    = out_degenerate ? '0 : res[2];
  assign out_y_offset   = out_degenerate ? '0 : res[3];
  assign out_z_scale    = out_degenerate ? '0 : res[4];
  assign out_z_offset   = out_degenerate ? '0 : res[5];
endmodule
`default_nettype wire

// File: src/pmb_checker.sv
// ----------------------------------------------------------------------------
// pmb_checker
// Port-level checks for the projection matrix builder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "projection_matrix_builder_top_defines.svh"
module pmb_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [pmb_pkg::DATA_W-1:0]  out_x_scale,
  input wire logic [pmb_pkg::DATA_W-1:0]  out_z_offset,
  input wire logic                        out_degenerate
);
  import pmb_pkg::*;

  `PMB_ASSERT_NOW(a_deg_zero, clk, rst_n, out_valid && out_degenerate, (out_x_scale == '0) && (out_z_offset == '0))
  `PMB_ASSERT_NOW(a_in_flow, clk, rst_n, !(out_valid && out_stall), !in_stall)
  `PMB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x_scale))
endmodule

bind projection_matrix_builder_top pmb_checker u_pmb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_x_scale    (out_x_scale),
  .out_z_offset   (out_z_offset),
  .out_degenerate (out_degenerate)
);
`default_nettype wire

// File: tb/projection_matrix_builder_checker.sv
// ----------------------------------------------------------------------------
// projection_matrix_builder_checker
// Watches both channels of the projection matrix builder. For each accepted
// bound set it computes the expected frustum or ortho terms, then compares
// every accepted result against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module projection_matrix_builder_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic                       in_func,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_left_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_right_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_bottom_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_top_bound,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_near_plane,
  input  wire logic [pmb_pkg::DATA_W-1:0] in_far_plane,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_x_scale,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_x_offset,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_y_scale,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_y_offset,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_z_scale,
  input  wire logic [pmb_pkg::DATA_W-1:0] out_z_offset,
  input  wire logic                       out_degenerate,
  output int                              fail_count,
  output int                              pending_count,
  output int                              matrix_count,
  output int                              degenerate_count
);
  import pmb_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] xs, xo, ys, yo, zs, zo;
    logic              degen;
  } terms_t;

  terms_t matrix_queue[$];

  function automatic logic [DATA_W-1:0] clamp_q16(longint q);
    if (q > 64'sd2147483647) return SAT_POS;
    if (q < -64'sd2147483648) return SAT_NEG;
    return q[DATA_W-1:0];
  endfunction

  function automatic terms_t projection_terms(logic func, logic [DATA_W-1:0] lb,
      logic [DATA_W-1:0] rb, logic [DATA_W-1:0] bb, logic [DATA_W-1:0] tb,
      logic [DATA_W-1:0] nb, logic [DATA_W-1:0] fb);
    longint l, r, b, t, n, f, dx, dy, dz, two32;
    terms_t res;
    l = longint'($signed(lb)); r = longint'($signed(rb));
    b = longint'($signed(bb)); t = longint'($signed(tb));
    n = longint'($signed(nb)); f = longint'($signed(fb));
    dx = r - l; dy = t - b; dz = f - n;
    two32 = 64'sd8589934592;
    res = '0;
    if (dx == 0 || dy == 0 || dz == 0) begin
      res.degen = 1'b1;
      return res;
    end
    if (func == FUNC_ORTHO) begin
      res.xs = clamp_q16(two32 / dx);
      res.xo = clamp_q16(-(((r + l) * 65536) / dx));
      res.ys = clamp_q16(two32 / dy);
      res.yo = clamp_q16(-(((t + b) * 65536) / dy));
      res.zs = clamp_q16(-(two32 / dz));
      res.zo = clamp_q16(-(((f + n) * 65536) / dz));
    end else begin
      res.xs = clamp_q16(((2 * n) * 65536) / dx);
      res.xo = clamp_q16(((r + l) * 65536) / dx);
      res.ys = clamp_q16(((2 * n) * 65536) / dy);
      res.yo = clamp_q16(((t + b) * 65536) / dy);
      res.zs = clamp_q16(-(((f + n) * 65536) / dz));
      res.zo = clamp_q16(-((2 * (f * n)) / dz));
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    matrix_count = 0;
    degenerate_count = 0;
  end

  always @(posedge clk) begin
    terms_t want, got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        matrix_queue.push_back(projection_terms(in_func, in_left_bound, in_right_bound,
            in_bottom_bound, in_top_bound, in_near_plane, in_far_plane));
      if (out_valid && !out_stall) begin
        got = '{out_x_scale, out_x_offset, out_y_scale, out_y_offset,
                out_z_scale, out_z_offset, out_degenerate};
        matrix_count++;
        if (out_degenerate) degenerate_count++;
        if (matrix_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = matrix_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch on result %0d", matrix_count);
              $display("  expected xs=%h xo=%h ys=%h yo=%h zs=%h zo=%h degen=%b",
                       want.xs, want.xo, want.ys, want.yo, want.zs, want.zo, want.degen);
              $display("  actual   xs=%h xo=%h ys=%h yo=%h zs=%h zo=%h degen=%b",
                       got.xs, got.xo, got.ys, got.yo, got.zs, got.zo, got.degen);
            end
          end
        end
      end
      pending_count = matrix_queue.size();
    end
  end
endmodule
`default_nettype wire

// File: tb/projection_matrix_builder_top_tb.sv
// ----------------------------------------------------------------------------
// projection_matrix_builder_top_tb
// Stimulus and verdict for the projection matrix builder. Directed bound sets
// hit the Q16.16 extremes, zero divisors on each axis and saturation in both
// modes, then random sets run under four sender and receiver idling phases.
// ----------------------------------------------------------------------------
`default_nettype none
module projection_matrix_builder_top_tb;
  import pmb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_FRUSTUM;
  logic [DATA_W-1:0] in_left_bound = '0, in_right_bound = '0, in_bottom_bound = '0;
  logic [DATA_W-1:0] in_top_bound = '0, in_near_plane = '0, in_far_plane = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_x_scale, out_x_offset, out_y_scale, out_y_offset;
  logic [DATA_W-1:0] out_z_scale, out_z_offset;
  logic out_degenerate;
  int fail_count, pending_count, matrix_count, degenerate_count;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #1 clk = ~clk;

  projection_matrix_builder_top u_top (.*);

  projection_matrix_builder_checker u_checker (.*);

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_bounds(logic func, logic [DATA_W-1:0] l, logic [DATA_W-1:0] r,
      logic [DATA_W-1:0] b, logic [DATA_W-1:0] t, logic [DATA_W-1:0] n,
      logic [DATA_W-1:0] f);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_left_bound <= l; in_right_bound <= r;
    in_bottom_bound <= b; in_top_bound <= t;
    in_near_plane <= n; in_far_plane <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return SAT_POS - $urandom_range(0, 3);
      2: return SAT_NEG + $urandom_range(0, 3);
      3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  task automatic send_random();
    logic [DATA_W-1:0] l, r, b, t, n, f;
    l = pick_bound(); r = pick_bound(); b = pick_bound();
    t = pick_bound(); n = pick_bound(); f = pick_bound();
    case ($urandom_range(0, 19))
      0: r = l;
      1: t = b;
      2: f = n;
      default: ;
    endcase
    send_bounds(logic'($urandom_range(0, 1)), l, r, b, t, n, f);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int m = 0; m < 2; m++) begin
      send_bounds(m[0], 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                  32'h0001_0000, 32'h0064_0000);
      send_bounds(m[0], SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
      send_bounds(m[0], SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG);
      send_bounds(m[0], 32'h0000_0005, 32'h0000_0005, 32'h0, 32'h1, 32'h1, 32'h2);
      send_bounds(m[0], 32'h0, 32'h1, 32'h1234_0000, 32'h1234_0000, 32'h1, 32'h2);
      send_bounds(m[0], 32'h0, 32'h1, 32'h0, 32'h1, SAT_NEG, SAT_NEG);
      send_bounds(m[0], 32'h0, 32'h1, 32'h0, 32'h1, SAT_POS, 32'h7FFF_FFFE);
      send_bounds(m[0], 32'h0, 32'h1, SAT_NEG, SAT_NEG + 1, SAT_NEG, SAT_NEG + 1);
      send_bounds(m[0], 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_bounds(m[0], 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 32'hFFFE_0000,
                  32'hFFFF_0000, 32'h0003_0000);
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      repeat (185) send_random();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices (%0d degenerate) in both modes over four idling phases",
             matrix_count, degenerate_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", pending_count);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/pmb_pkg.sv
src/pmb_divider.sv
src/projection_matrix_builder_top.sv
src/pmb_checker.sv
tb/projection_matrix_builder_checker.sv
tb/projection_matrix_builder_top_tb.sv
